### design/pru_pkg.sv
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants for the PNG row unfilter: filter codes,
// register indexes, field widths and the item that the front end hands to
// the reconstruction back end.
// ----------------------------------------------------------------------------
package pru_pkg;

  // Sizing defaults for the top-level parameters.
  localparam int DEF_MAX_ROW_BYTES   = 16384;
  localparam int DEF_MAX_PIXEL_BYTES = 8;

  // Fixed field widths.
  localparam int ROW_LEN_W = 15;
  localparam int PIX_BYTES_W = 4;
  localparam int CNT_W = 15;
  // Wide enough for any row length up to the largest line store.
  localparam int CMP_W = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 15;

  // Register reset values.
  localparam logic [ROW_LEN_W-1:0]   ROW_LEN_RESET   = 15'd4096;
  localparam logic [PIX_BYTES_W-1:0] PIX_BYTES_RESET = 4'd4;

  // Depth of the queue between front end and back end.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH  = 1'b0,
    CFG_PIXEL_BYTES = 1'b1
  } cfg_index_t;

  // PNG filter types.
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  // Register contents seen by the front and back ends.
  typedef struct packed {
    logic [ROW_LEN_W-1:0]   row_length;
    logic [PIX_BYTES_W-1:0] pixel_bytes;
  } pru_cfg_t;

  // One classified item: either a sample to rebuild or a bad-filter status.
  typedef struct packed {
    logic             status;     // bad-filter status item, no sample
    logic [7:0]       data;       // filtered sample byte
    filter_t          filt;       // filter of this row
    logic             first_row;  // row above reads as zero
    logic             sticky;     // image has met a bad filter type
    logic             last;       // last sample of the row
    logic             row_start;  // first sample of the row
    logic [CNT_W-1:0] col;        // column of the sample
  } pru_item_t;

endpackage

### design/pru_in_if.sv
// ----------------------------------------------------------------------------
// pru_in_if
// Input channel of the row unfilter: one inflated byte per item.
// ----------------------------------------------------------------------------
interface pru_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_image;

  modport source (output valid, output data_byte, output first_of_image, input ready);
  modport sink (input valid, input data_byte, input first_of_image, output ready);
endinterface

### design/pru_out_if.sv
// ----------------------------------------------------------------------------
// pru_out_if
// Result channel of the row unfilter: one reconstructed byte or status per
// item.
// ----------------------------------------------------------------------------
interface pru_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       end_of_row;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output end_of_row, output bad_filter,
                  input ready);
  modport sink (input valid, input pixel_byte, input end_of_row, input bad_filter,
                output ready);
endinterface

### design/pru_front.sv
// ----------------------------------------------------------------------------
// pru_front
// Front end: accepts input bytes, tracks the row structure (filter byte,
// column count, first row, error flag) and pushes classified items.
// ----------------------------------------------------------------------------
module pru_front #(
  parameter int MAX_ROW_BYTES = pru_pkg::DEF_MAX_ROW_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pru_pkg::pru_cfg_t   cfg,
  pru_in_if.sink              in_ch,
  input  logic                q_full,
  output logic                q_push,
  output pru_pkg::pru_item_t  q_item
);
  import pru_pkg::*;

  typedef enum logic [1:0] {
    ST_FILTER = 2'b01,
    ST_SAMPLE = 2'b10
  } fr_state_t;

  fr_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  filter_t          filt_r, filt_nxt;
  logic             first_row_r, first_row_nxt;
  logic             sticky_r, sticky_nxt;

  logic             accept;
  logic             awaiting;
  logic             first_row_eff;
  logic             sticky_eff;
  logic             bad_code;
  logic [CMP_W-1:0] len_eff;
  logic [CMP_W-1:0] col_inc;
  logic             last;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Effective row length: zero acts as one, clamp to the line store size.
  always_comb begin
    len_eff = CMP_W'(cfg.row_length);
    if (len_eff == '0) begin
      len_eff = CMP_W'(1);
    end
    if (len_eff > CMP_W'(MAX_ROW_BYTES)) begin
      len_eff = CMP_W'(MAX_ROW_BYTES);
    end
  end

  // A new-image mark restarts the row structure on this very byte.
  assign first_row_eff = in_ch.first_of_image || first_row_r;
  assign sticky_eff    = !in_ch.first_of_image && sticky_r;
  assign awaiting      = in_ch.first_of_image || (state_r == ST_FILTER);
  assign bad_code      = in_ch.data_byte > 8'(FILT_PAETH);
  assign col_inc       = CMP_W'(col_r) + CMP_W'(1);
  assign last          = col_inc >= len_eff;

  // Classification and row bookkeeping.
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    filt_nxt      = filt_r;
    first_row_nxt = first_row_r;
    sticky_nxt    = sticky_r;
    q_push        = 1'b0;

    q_item.status    = 1'b0;
    q_item.data      = in_ch.data_byte;
    q_item.filt      = filt_r;
    q_item.first_row = first_row_eff;
    q_item.sticky    = sticky_eff;
    q_item.last      = last;
    q_item.row_start = (col_r == '0);
    q_item.col       = col_r;

    if (accept) begin
      first_row_nxt = first_row_eff;
      sticky_nxt    = sticky_eff;
      if (awaiting) begin
        state_nxt = ST_SAMPLE;
        col_nxt   = '0;
        if (bad_code) begin
          // Bad filter type: emit one status item, pass the row unfiltered.
          filt_nxt       = FILT_NONE;
          sticky_nxt     = 1'b1;
          q_push         = 1'b1;
          q_item.status  = 1'b1;
          q_item.data    = '0;
          q_item.sticky  = 1'b1;
          q_item.last    = 1'b0;
        end else begin
          filt_nxt = filter_t'(in_ch.data_byte[2:0]);
        end
      end else begin
        q_push = 1'b1;
        if (last) begin
          col_nxt       = '0;
          state_nxt     = ST_FILTER;
          first_row_nxt = 1'b0;
        end else begin
          col_nxt = col_inc[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILTER;
      col_r       <= '0;
      filt_r      <= FILT_NONE;
      first_row_r <= 1'b1;
      sticky_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      filt_r      <= filt_nxt;
      first_row_r <= first_row_nxt;
      sticky_r    <= sticky_nxt;
    end
  end

endmodule

### design/pru_queue.sv
// ----------------------------------------------------------------------------
// pru_queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pru_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pru_pkg::pru_item_t  push_item,
  input  logic                pop,
  output pru_pkg::pru_item_t  head_item,
  output logic                full,
  output logic                empty
);
  import pru_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  pru_item_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == CNT_QW'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_QW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### design/pru_back.sv
// ----------------------------------------------------------------------------
// pru_back
// Back end: reads the row above from the line store, rebuilds each sample
// with its filter, writes it back and holds the result in an output register.
// ----------------------------------------------------------------------------
module pru_back #(
  parameter int MAX_ROW_BYTES   = pru_pkg::DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = pru_pkg::DEF_MAX_PIXEL_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pru_pkg::pru_cfg_t   cfg,
  input  pru_pkg::pru_item_t  head_item,
  input  logic                q_empty,
  output logic                q_pop,
  pru_out_if.source           out_ch
);
  import pru_pkg::*;

  localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int LB_W   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // Line store holding the previous row.
  logic [7:0]        line_mem [MAX_ROW_BYTES];

  // Read stage: item plus its row-above byte.
  pru_item_t         s1_item_r;
  logic              s1_valid_r;
  logic [7:0]        rd_data_r;
  logic              fwd_r;
  logic [7:0]        fwd_data_r;

  // Last reconstructed bytes of this row and of the row above.
  logic [7:0]        left_r [MAX_PIXEL_BYTES];
  logic [7:0]        ul_r [MAX_PIXEL_BYTES];

  logic              out_valid_r;
  logic [7:0]        out_pixel_r;
  logic              out_eor_r;
  logic              out_bad_r;

  logic              exec_fire;
  logic              exec_write;
  logic              load_s1;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [PIX_BYTES_W-1:0] bpp;
  logic [LB_W-1:0]   tap;
  logic [7:0]        up;
  logic [7:0]        left;
  logic [7:0]        ul;
  logic [7:0]        pred;
  logic [7:0]        val;
  logic [8:0]        avg_sum;
  logic signed [9:0] pa_p;
  logic signed [9:0] da;
  logic signed [9:0] db;
  logic signed [9:0] dc;

  // Column to line store address, clamped to the store.
  function automatic logic [ADDR_W-1:0] col_to_addr(input logic [CNT_W-1:0] col);
    logic [CMP_W-1:0] c;
    c = CMP_W'(col);
    if (c >= CMP_W'(MAX_ROW_BYTES)) begin
      c = CMP_W'(MAX_ROW_BYTES - 1);
    end
    return c[ADDR_W-1:0];
  endfunction

  function automatic logic signed [9:0] abs10(input logic signed [9:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // Stage handshakes.
  assign exec_fire  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign exec_write = exec_fire && !s1_item_r.status;
  assign load_s1    = !q_empty && (!s1_valid_r || exec_fire);
  assign q_pop      = load_s1;
  assign rd_addr    = col_to_addr(head_item.col);
  assign wr_addr    = col_to_addr(s1_item_r.col);

  // Effective pixel size: zero acts as one, clamp to the tap count.
  always_comb begin
    bpp = cfg.pixel_bytes;
    if (bpp == '0) begin
      bpp = PIX_BYTES_W'(1);
    end
    if (bpp > PIX_BYTES_W'(MAX_PIXEL_BYTES)) begin
      bpp = PIX_BYTES_W'(MAX_PIXEL_BYTES);
    end
  end
  assign tap = LB_W'(bpp - PIX_BYTES_W'(1));

  // Neighbor bytes; left and up-left read as zero at the start of a row.
  assign up   = s1_item_r.first_row ? 8'd0 : (fwd_r ? fwd_data_r : rd_data_r);
  assign left = s1_item_r.row_start ? 8'd0 : left_r[tap];
  assign ul   = s1_item_r.row_start ? 8'd0 : ul_r[tap];

  // Prediction.
  assign avg_sum = {1'b0, left} + {1'b0, up};
  assign pa_p    = $signed({2'b00, left}) + $signed({2'b00, up}) - $signed({2'b00, ul});
  assign da      = abs10(pa_p - $signed({2'b00, left}));
  assign db      = abs10(pa_p - $signed({2'b00, up}));
  assign dc      = abs10(pa_p - $signed({2'b00, ul}));

  always_comb begin
    unique case (s1_item_r.filt)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (da <= db && da <= dc) begin
          pred = left;
        end else if (db <= dc) begin
          pred = up;
        end else begin
          pred = ul;
        end
      end
      default:    pred = 8'd0;
    endcase
  end

  assign val = s1_item_r.data + pred;

  // Read stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load_s1) begin
      s1_valid_r <= 1'b1;
    end else if (exec_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Read stage payload; a write to the same column in this cycle is forwarded.
  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_item_r  <= head_item;
      fwd_r      <= exec_write && (wr_addr == rd_addr);
      fwd_data_r <= val;
    end
  end

  // Line store ports.
  always_ff @(posedge clk) begin
    if (load_s1) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (exec_write) begin
      line_mem[wr_addr] <= val;
    end
  end

  // Neighbor history shifts on every rebuilt sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i] <= '0;
        ul_r[i]   <= '0;
      end
    end else if (exec_write) begin
      left_r[0] <= val;
      ul_r[0]   <= up;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i] <= s1_item_r.row_start ? 8'd0 : left_r[i-1];
        ul_r[i]   <= s1_item_r.row_start ? 8'd0 : ul_r[i-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_pixel_r <= s1_item_r.status ? 8'd0 : val;
      out_eor_r   <= !s1_item_r.status && s1_item_r.last;
      out_bad_r   <= s1_item_r.sticky;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_byte = out_pixel_r;
  assign out_ch.end_of_row = out_eor_r;
  assign out_ch.bad_filter = out_bad_r;

endmodule

### design/png_row_unfilter.sv
// ----------------------------------------------------------------------------
// png_row_unfilter
// PNG scanline reconstruction: removes None, Sub, Up, Average and Paeth
// filters from an inflated byte stream using a one-row line store.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and gives one result per sample byte a
// cycle while the result side is ready. A sample's result passes through the
// queue slot, the line store read stage and the output register, in order.
// A filter byte gives no result unless its type is above 4, in which case it
// gives one status result that passes through the same stages. The line
// store has one read port and one write port, is read one stage ahead of the
// reconstruction stage, and a write of the same column is forwarded to the
// next read. A two-item queue separates the input side from the
// reconstruction side so a stalled result does not block accepts until the
// queue fills. The line store is not cleared at reset; columns of the row
// above that were never written in the current image's history read as
// unknown.
// ----------------------------------------------------------------------------
module png_row_unfilter #(
  parameter int MAX_ROW_BYTES   = pru_pkg::DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = pru_pkg::DEF_MAX_PIXEL_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pru_in_if.sink                           in_ch,
  pru_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [pru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pru_pkg::*;

  logic [ROW_LEN_W-1:0]   row_length_r;
  logic [PIX_BYTES_W-1:0] pixel_bytes_r;
  pru_cfg_t               cfg;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  pru_item_t              push_item;
  pru_item_t              head_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r  <= ROW_LEN_RESET;
      pixel_bytes_r <= PIX_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ROW_LENGTH:  row_length_r  <= cfg_wdata[ROW_LEN_W-1:0];
        CFG_PIXEL_BYTES: pixel_bytes_r <= cfg_wdata[PIX_BYTES_W-1:0];
        default:         row_length_r  <= row_length_r;
      endcase
    end
  end

  assign cfg.row_length  = row_length_r;
  assign cfg.pixel_bytes = pixel_bytes_r;

  // Front end: row structure and classification.
  pru_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  // Queue between the two sides.
  pru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: line store and reconstruction.
  pru_back #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head_item (head_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

  // The queue can never be full and empty at once.
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  // Items enter the queue only from an accepted input byte.
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_ch.valid && in_ch.ready))
    else $error("queue push without an accepted input item");

  // The back end takes an item only when one is queued.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // A push into an empty queue leaves it non-empty on the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_empty) |=> !q_empty)
    else $error("pushed item lost by the queue");

endmodule
